// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the motion time accumulator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mta_pkg.sv -----
// ----------------------------------------------------------------------------
// mta_pkg
// Types and constants shared by the motion time accumulator modules.
// ----------------------------------------------------------------------------
package mta_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 32;
  localparam int TIME_W     = POS_W + FRAC_BITS;
  localparam int SQ_W       = 2 * POS_W;
  localparam int SQ_TERMS   = 3;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int Q_CNT_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 6;

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [TIME_W-1:0]       TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CFG_DATA_W-1:0]   FEED_RESET = CFG_DATA_W'(1) << FRAC_BITS;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FEED_RATE = 3'd0;
  localparam cfg_idx_t REG_START_X   = 3'd1;
  localparam cfg_idx_t REG_START_Y   = 3'd2;
  localparam cfg_idx_t REG_START_Z   = 3'd3;

  typedef enum logic {
    OP_MOVE  = 1'b0,
    OP_DWELL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [POS_W-1:0] delta_x;
    logic signed [POS_W-1:0] delta_y;
    logic signed [POS_W-1:0] delta_z;
    logic [POS_W-1:0]        dwell_time;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]       out_time;
    logic signed [POS_W-1:0] out_x;
    logic signed [POS_W-1:0] out_y;
    logic signed [POS_W-1:0] out_z;
    logic                    overflow;
  } res_t;

  // Classified command handed from the front to the back end
  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        mag_x;
    logic [POS_W-1:0]        mag_y;
    logic [POS_W-1:0]        mag_z;
    logic [POS_W-1:0]        dwell_time;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    pos_ovf;
  } job_t;

  typedef struct packed {
    logic                  feed_we;
    logic                  start_x_we;
    logic                  start_y_we;
    logic                  start_z_we;
    logic [CFG_DATA_W-1:0] data;
  } cfg_ctl_t;

endpackage

// ----- rtl/core/cnc_move_time_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// cnc_move_time_accumulator_core
// Motion time and position accumulator for relative moves and dwells.
// ----------------------------------------------------------------------------
// Flow: a dwell goes from acceptance straight to the result; a move runs the
//   sum of squares, the 32-step square root and the 48-step divider, and
//   skips the divider when the distance or the feed rate is zero. The back
//   end works on one command at a time; the queue holds the next ones.
// Reset: synchronous; position and time cleared, feed rate 1.0, queue empty.
module cnc_move_time_accumulator_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mta_pkg::item_t            in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mta_pkg::res_t             out_data,
  input  logic                      cfg_we,
  input  mta_pkg::cfg_idx_t         cfg_index,
  input  logic [mta_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mta_pkg::*;

  cfg_ctl_t cfg;
  job_t     front_job;
  job_t     q_data;
  logic     q_full, q_empty, q_pop, push;

  always_comb begin
    cfg            = '0;
    cfg.data       = cfg_data;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FEED_RATE: cfg.feed_we    = 1'b1;
        REG_START_X:   cfg.start_x_we = 1'b1;
        REG_START_Y:   cfg.start_y_we = 1'b1;
        REG_START_Z:   cfg.start_z_we = 1'b1;
        default:       ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  mta_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_data (in_data),
    .push    (push),
    .job     (front_job)
  );

  mta_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_job),
    .pop     (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  mta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/mta_fifo.sv -----
// ----------------------------------------------------------------------------
// mta_fifo
// Short job queue between the command front end and the timing back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mta_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mta_pkg::job_t wr_data,
  input  logic          pop,
  output mta_pkg::job_t rd_data,
  output logic          full,
  output logic          empty
);
  import mta_pkg::*;

  job_t                 mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, cnt_r != '0, "pop from empty queue")
  `ASSERT_NEXT(a_push_counts, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + Q_CNT_W'(1), "push not counted")

endmodule

// ----- rtl/core/mta_front.sv -----
// ----------------------------------------------------------------------------
// mta_front
// Command front end: keeps the position, applies saturating axis moves and
// hands the absolute per-axis travel on to the back end.
// ----------------------------------------------------------------------------
module mta_front (
  input  logic              clk,
  input  logic              rst_n,
  input  mta_pkg::cfg_ctl_t cfg,
  input  mta_pkg::item_t    in_data,
  input  logic              push,
  output mta_pkg::job_t     job
);
  import mta_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [POS_W-1:0]        mag;
    logic                    ovf;
  } axis_t;

  function automatic axis_t step_axis(logic signed [POS_W-1:0] old,
                                      logic signed [POS_W-1:0] delta);
    logic [POS_W:0]   sum;
    logic [POS_W-1:0] dmag;
    axis_t            a;
    sum  = {old[POS_W-1], old} + {delta[POS_W-1], delta};
    dmag = delta[POS_W-1] ? (~delta + POS_W'(1)) : delta;
    a.ovf = sum[POS_W] ^ sum[POS_W-1];
    if (a.ovf && !sum[POS_W]) begin
      // clamped high: travel is POS_MAX - old
      a.pos = POS_MAX;
      a.mag = {old[POS_W-1], ~old[POS_W-2:0]};
    end else if (a.ovf) begin
      // clamped low: travel is old - POS_MIN
      a.pos = POS_MIN;
      a.mag = {~old[POS_W-1], old[POS_W-2:0]};
    end else begin
      a.pos = sum[POS_W-1:0];
      a.mag = dmag;
    end
    return a;
  endfunction

  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [POS_W-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  axis_t                   ax, ay, az;
  logic                    is_move;

  assign is_move = (in_data.op == OP_MOVE);
  assign ax = step_axis(pos_x_r, in_data.delta_x);
  assign ay = step_axis(pos_y_r, in_data.delta_y);
  assign az = step_axis(pos_z_r, in_data.delta_z);

  always_comb begin
    job.op         = in_data.op;
    job.dwell_time = in_data.dwell_time;
    if (is_move) begin
      job.mag_x   = ax.mag;
      job.mag_y   = ay.mag;
      job.mag_z   = az.mag;
      job.pos_x   = ax.pos;
      job.pos_y   = ay.pos;
      job.pos_z   = az.pos;
      job.pos_ovf = ax.ovf | ay.ovf | az.ovf;
    end else begin
      job.mag_x   = '0;
      job.mag_y   = '0;
      job.mag_z   = '0;
      job.pos_x   = pos_x_r;
      job.pos_y   = pos_y_r;
      job.pos_z   = pos_z_r;
      job.pos_ovf = 1'b0;
    end
  end

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (push) begin
      pos_x_nxt = job.pos_x;
      pos_y_nxt = job.pos_y;
      pos_z_nxt = job.pos_z;
    end
    // start register writes load the position directly
    if (cfg.start_x_we) pos_x_nxt = cfg.data;
    if (cfg.start_y_we) pos_y_nxt = cfg.data;
    if (cfg.start_z_we) pos_z_nxt = cfg.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      pos_z_r <= pos_z_nxt;
    end
  end

endmodule

// ----- rtl/core/mta_back.sv -----
// ----------------------------------------------------------------------------
// mta_back
// Timing back end: sum of squares on a shared multiplier, bit-serial integer
// square root, restoring divide by the feed rate, saturating time update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mta_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mta_pkg::cfg_ctl_t cfg,
  input  logic              q_empty,
  input  mta_pkg::job_t     q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mta_pkg::res_t     out_data
);
  import mta_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQ   = 6'b000010,
    ST_ROOT = 6'b000100,
    ST_SEL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  job_t                job_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SQ_W-1:0]     prod_r;
  logic [SQ_W-1:0]     acc_r;
  logic [SQ_W-1:0]     root_r;
  logic [SQ_W-1:0]     bit_r;
  logic [POS_W-1:0]    rem_r;
  logic [TIME_W-1:0]   dq_r;
  logic                force_ovf_r;
  logic [TIME_W-1:0]   time_r;
  logic [POS_W-1:0]    feed_r;
  logic                out_valid_r;
  res_t                out_r;

  logic [POS_W-1:0]    mag_sel;
  logic [SQ_W-1:0]     sq_w;
  logic [SQ_W-1:0]     root_t;
  logic                root_ge;
  logic [POS_W:0]      rem_sh;
  logic                div_ge;
  logic [POS_W:0]      rem_sub;
  logic [TIME_W:0]     tsum;
  logic [TIME_W-1:0]   time_nxt;
  logic                fin_go;
  logic                sq_last;
  logic [POS_W-1:0]    travel;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mag_sel = job_r.mag_x;
      2'd1:    mag_sel = job_r.mag_y;
      default: mag_sel = job_r.mag_z;
    endcase
  end

  assign sq_w    = mag_sel * mag_sel;
  assign sq_last = (cnt_r == CNT_W'(SQ_TERMS));

  assign root_t  = root_r + bit_r;
  assign root_ge = (acc_r >= root_t);
  assign travel  = root_r[POS_W-1:0];

  assign rem_sh  = {rem_r, dq_r[TIME_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, feed_r});
  assign rem_sub = rem_sh - {1'b0, feed_r};

  assign tsum     = {1'b0, time_r} + {1'b0, dq_r};
  assign time_nxt = tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_data.op == OP_DWELL) ? ST_FIN : ST_SQ;
        end
      end
      ST_SQ: begin
        if (sq_last) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (bit_r[0]) state_nxt = ST_SEL;
      end
      ST_SEL: begin
        state_nxt = ((travel == '0) || (feed_r == '0)) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(TIME_W - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      feed_r      <= FEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.feed_we) begin
        feed_r <= cfg.data;
      end
      if (fin_go) begin
        time_r      <= time_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        job_r       <= q_data;
        cnt_r       <= '0;
        acc_r       <= '0;
        force_ovf_r <= 1'b0;
        dq_r        <= {{(TIME_W-POS_W){1'b0}}, q_data.dwell_time};
      end
      ST_SQ: begin
        prod_r <= sq_w;
        cnt_r  <= cnt_r + CNT_W'(1);
        // product of the previous term is registered and added in the following cycle
        if (cnt_r != '0) begin
          acc_r <= acc_r + prod_r;
        end
        root_r <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
      end
      ST_ROOT: begin
        if (root_ge) begin
          acc_r  <= acc_r - root_t;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_SEL: begin
        cnt_r <= '0;
        rem_r <= '0;
        if (travel == '0) begin
          dq_r <= '0;
        end else if (feed_r == '0) begin
          dq_r        <= TIME_MAX;
          force_ovf_r <= 1'b1;
        end else begin
          dq_r <= {travel, {FRAC_BITS{1'b0}}};
        end
      end
      ST_DIV: begin
        rem_r <= div_ge ? rem_sub[POS_W-1:0] : rem_sh[POS_W-1:0];
        dq_r  <= {dq_r[TIME_W-2:0], div_ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ST_FIN: begin
        if (fin_go) begin
          out_r.out_time <= time_nxt;
          out_r.out_x    <= job_r.pos_x;
          out_r.out_y    <= job_r.pos_y;
          out_r.out_z    <= job_r.pos_z;
          out_r.overflow <= job_r.pos_ovf | tsum[TIME_W] | force_ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMPLIES(a_div_feed, clk, rst_n, state_r == ST_DIV, feed_r != '0, "divide by zero feed")
  `ASSERT_NEXT(a_hold_result, clk, rst_n, (state_r == ST_FIN) && out_valid_r && out_stall, (state_r == ST_FIN) && $stable(out_r), "result overwritten while held")
  `ASSERT_IMPLIES(a_pop_idle, clk, rst_n, q_pop, !fin_go && (state_r == ST_IDLE), "pop outside idle")

endmodule

// ----- bench/tb_cnc_move_time_accumulator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cnc_move_time_accumulator_core
// Self-checking bench for the motion time accumulator. A short table of
// directed commands and register writes runs first. Random phases follow,
// each with its own feed rate and start position. A closing table drives the
// elapsed time into saturation, then moves at zero feed. Each result is checked
// field by field against an in-bench model of position, distance and time or a
// fixed value; commands idle and results stall at random but in the final stretch.
// ----------------------------------------------------------------------------
module tb_cnc_move_time_accumulator_core;
  import mta_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 275;
  localparam cfg_idx_t REG_SPARE = 3'd4;  // first unmapped register index

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  item_t                 in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  res_t                  out_data;
  logic                  cfg_we    = 1'b0;
  cfg_idx_t              cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  cnc_move_time_accumulator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracked machine state, as after reset
  logic [POS_W-1:0]        track_feed = FEED_RESET;
  logic signed [POS_W-1:0] track_x    = '0;
  logic signed [POS_W-1:0] track_y    = '0;
  logic signed [POS_W-1:0] track_z    = '0;
  logic [TIME_W-1:0]       track_time = '0;

  res_t motion_q[$];  // pending position/time results, oldest first

  typedef struct {
    bit                    is_write;
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    item_t                 cmd;
    bit                    known;
    res_t                  want;
  } row_t;
  row_t plan[$];

  bit idle_on = 1'b1;
  int errors, quiet_cycles;
  int n_moves, n_dwells, n_writes, n_checked, n_sat;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 40) $display("%0t ERROR %s", $time, msg);
  endtask

  // Clamped axis update; returns the squared size of the actual change
  function automatic logic [63:0] axis_move(inout logic signed [POS_W-1:0] pos,
                                            input logic signed [POS_W-1:0] delta,
                                            inout bit sat);
    longint      sum;
    longint      chg;
    logic [63:0] mag;
    sum = longint'(pos) + longint'(delta);
    if (sum > longint'(POS_MAX)) begin
      sum = longint'(POS_MAX);
      sat = 1'b1;
    end
    if (sum < longint'(POS_MIN)) begin
      sum = longint'(POS_MIN);
      sat = 1'b1;
    end
    chg = sum - longint'(pos);
    pos = sum[POS_W-1:0];
    mag = (chg < 0) ? -chg : chg;
    return mag * mag;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rem, root, b;
    rem  = v;
    root = '0;
    b    = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic void add_elapsed(input logic [63:0] inc, inout bit sat);
    if (inc > TIME_MAX - track_time) begin
      track_time = TIME_MAX;
      sat = 1'b1;
    end else begin
      track_time = track_time + inc[TIME_W-1:0];
    end
  endfunction

  function automatic res_t advance_motion(input item_t c);
    bit          sat;
    logic [63:0] sq, travel;
    res_t        r;
    sat = 1'b0;
    if (c.op == OP_MOVE) begin
      sq = axis_move(track_x, c.delta_x, sat);
      sq = sq + axis_move(track_y, c.delta_y, sat);
      sq = sq + axis_move(track_z, c.delta_z, sat);
      travel = floor_root(sq);
      if (travel != 0) begin
        if (track_feed == 0) begin
          add_elapsed(64'(TIME_MAX), sat);
          if (track_time == TIME_MAX) sat = 1'b1;
        end else begin
          add_elapsed((travel << FRAC_BITS) / 64'(track_feed), sat);
        end
      end
    end else begin
      add_elapsed(64'(c.dwell_time), sat);
    end
    r.out_time = track_time;
    r.out_x    = track_x;
    r.out_y    = track_y;
    r.out_z    = track_z;
    r.overflow = sat;
    return r;
  endfunction

  // Writes only once every pending result is back; every command returns one
  task automatic load_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FEED_RATE: track_feed = val;
      REG_START_X:   track_x = val;
      REG_START_Y:   track_y = val;
      REG_START_Z:   track_z = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic send_cmd(input item_t c, input bit known, input res_t want);
    res_t pred;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_motion(c);  // always run, keeps tracked state in step
    motion_q = {motion_q, (known ? want : pred)};
    if (c.op == OP_MOVE) n_moves++;
    else n_dwells++;
  endtask

  task automatic run_rows(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      if (plan[i].is_write) load_reg(plan[i].idx, plan[i].val);
      else send_cmd(plan[i].cmd, plan[i].known, plan[i].want);
    end
  endtask

  function automatic void plan_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx      = idx;
    r.val      = val;
    plan = {plan, r};
  endfunction

  function automatic void plan_cmd(input op_t op, input logic [POS_W-1:0] dx,
                                   input logic [POS_W-1:0] dy, input logic [POS_W-1:0] dz,
                                   input logic [POS_W-1:0] dw);
    row_t r;
    r = '{default: '0};
    r.cmd.op         = op;
    r.cmd.delta_x    = dx;
    r.cmd.delta_y    = dy;
    r.cmd.delta_z    = dz;
    r.cmd.dwell_time = dw;
    plan = {plan, r};
  endfunction

  function automatic void plan_known(input op_t op, input logic [POS_W-1:0] dx,
                                     input logic [POS_W-1:0] dy, input logic [POS_W-1:0] dz,
                                     input logic [POS_W-1:0] dw, input res_t want);
    plan_cmd(op, dx, dy, dz, dw);
    plan[plan.size()-1].known = 1'b1;
    plan[plan.size()-1].want  = want;
  endfunction

  function automatic logic [POS_W-1:0] random_delta(input bit slow);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (slow) return (pick == 0) ? '0 : $urandom_range(0, 8192) - 4096;
    case (pick) inside
      0:       return '0;
      1:       return POS_MAX;
      2:       return POS_MIN;
      3:       return $urandom_range(0, 1) ? 32'h1 : 32'hFFFF_FFFF;
      [4:6]:   return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_start();
    case ($urandom_range(0, 5))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (motion_q.size() == 0) begin
        flag_error($sformatf("result %h with nothing pending", out_data));
      end else begin
        want = motion_q.pop_front();
        n_checked++;
        if (out_data.overflow) n_sat++;
        if (out_data.out_time !== want.out_time)
          flag_error($sformatf("result %0d: out_time %h, expected %h",
                               n_checked, out_data.out_time, want.out_time));
        if (out_data.out_x !== want.out_x)
          flag_error($sformatf("result %0d: out_x %h, expected %h",
                               n_checked, out_data.out_x, want.out_x));
        if (out_data.out_y !== want.out_y)
          flag_error($sformatf("result %0d: out_y %h, expected %h",
                               n_checked, out_data.out_y, want.out_y));
        if (out_data.out_z !== want.out_z)
          flag_error($sformatf("result %0d: out_z %h, expected %h",
                               n_checked, out_data.out_z, want.out_z));
        if (out_data.overflow !== want.overflow)
          flag_error($sformatf("result %0d: overflow %b, expected %b",
                               n_checked, out_data.overflow, want.overflow));
      end
    end
  end

  // Watchdog: cycles without a transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_cnc_move_time_accumulator_core: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          tail_at;
    bit          slow;
    logic [31:0] feed;
    item_t       c;

    // Directed: reset defaults, ignored fields, axis clamping, feed extremes
    plan_known(OP_DWELL, '0, '0, '0, '0, res_t'{48'h0, 32'h0, 32'h0, 32'h0, 1'b0});
    plan_known(OP_DWELL, POS_MAX, POS_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               res_t'{48'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0});
    plan_known(OP_MOVE, 32'h3_0000, 32'h4_0000, '0, 32'hFFFF_FFFF,
               res_t'{48'h1_0004_FFFF, 32'h3_0000, 32'h4_0000, 32'h0, 1'b0});
    plan_known(OP_MOVE, '0, '0, '0, '0,
               res_t'{48'h1_0004_FFFF, 32'h3_0000, 32'h4_0000, 32'h0, 1'b0});
    plan_cmd(OP_MOVE, POS_MAX, '0, '0, '0);
    plan_cmd(OP_MOVE, '0, POS_MIN, '0, '0);
    plan_cmd(OP_MOVE, '0, POS_MIN, POS_MIN, '0);
    plan_cmd(OP_MOVE, 32'h1, 32'hFFFF_FFFF, 32'h1, '0);
    plan_cmd(OP_MOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    plan_cmd(OP_MOVE, POS_MIN, POS_MAX, POS_MAX, '0);
    plan_write(REG_FEED_RATE, 32'hFFFF_FFFF);
    plan_write(REG_START_X, POS_MAX);
    plan_write(REG_START_Y, POS_MIN);
    plan_write(REG_START_Z, 32'hFFFF_FFFF);
    plan_cmd(OP_MOVE, 32'h1, 32'hFFFF_FFFF, 32'h1, '0);
    plan_cmd(OP_MOVE, POS_MIN, POS_MAX, '0, '0);
    plan_cmd(OP_DWELL, '0, '0, '0, 32'h1);
    // zero feed, but only moves that end up with no travel
    plan_write(REG_FEED_RATE, '0);
    plan_write(REG_START_X, POS_MAX);
    plan_write(REG_START_Y, POS_MIN);
    plan_write(REG_START_Z, '0);
    plan_write(cfg_idx_t'(REG_SPARE + 3), 32'hDEAD_BEEF);
    plan_cmd(OP_MOVE, '0, '0, '0, '0);
    plan_cmd(OP_MOVE, 32'h5, 32'hFFFF_FFFB, '0, '0);  // clamped on both axes, no travel
    plan_cmd(OP_DWELL, '0, '0, '0, 32'h1_0000);

    // Closing part: time saturation, then zero feed with travel
    tail_at = plan.size();
    plan_write(REG_FEED_RATE, 32'h1);
    plan_write(REG_START_X, '0);
    plan_write(REG_START_Y, '0);
    plan_write(REG_START_Z, '0);
    plan_cmd(OP_MOVE, POS_MAX, POS_MAX, POS_MAX, '0);
    plan_cmd(OP_MOVE, POS_MIN, POS_MIN, POS_MIN, '0);
    plan_write(REG_START_X, '0);
    plan_write(REG_START_Y, '0);
    plan_write(REG_START_Z, '0);
    plan_known(OP_DWELL, '0, '0, '0, '0, res_t'{TIME_MAX, 32'h0, 32'h0, 32'h0, 1'b0});
    plan_known(OP_DWELL, '0, '0, '0, 32'h1, res_t'{TIME_MAX, 32'h0, 32'h0, 32'h0, 1'b1});
    plan_known(OP_MOVE, '0, '0, '0, '0, res_t'{TIME_MAX, 32'h0, 32'h0, 32'h0, 1'b0});
    plan_known(OP_MOVE, 32'h1_0000, '0, '0, '0,
               res_t'{TIME_MAX, 32'h1_0000, 32'h0, 32'h0, 1'b1});
    plan_write(REG_FEED_RATE, '0);
    plan_known(OP_MOVE, '0, 32'h1_0000, '0, '0,
               res_t'{TIME_MAX, 32'h1_0000, 32'h1_0000, 32'h0, 1'b1});
    plan_known(OP_MOVE, '0, '0, '0, '0,
               res_t'{TIME_MAX, 32'h1_0000, 32'h1_0000, 32'h0, 1'b0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_rows(0, tail_at);

    // Slow phases pair a low feed with short moves so the time stays clear of
    // saturation until the closing part
    for (int p = 0; p < RAND_PHASES; p++) begin
      slow = p[0];
      if (p == RAND_PHASES - 1) idle_on = 1'b0;
      if (p == 1) feed = 32'h1;
      else if (p == 2) feed = 32'hFFFF_FFFF;
      else if (slow) feed = $urandom_range(1, 32'hFFFF);
      else feed = $urandom_range(32'h1_0000, 32'hFFFF_FFFF);
      load_reg(REG_FEED_RATE, feed);
      load_reg(REG_START_X, random_start());
      load_reg(REG_START_Y, random_start());
      load_reg(REG_START_Z, random_start());
      if ($urandom_range(0, 1)) load_reg(cfg_idx_t'(REG_SPARE + $urandom_range(0, 3)), $urandom);
      repeat (PHASE_ITEMS) begin
        c.op         = ($urandom_range(0, 9) < 6) ? OP_MOVE : OP_DWELL;
        c.delta_x    = random_delta(slow);
        c.delta_y    = random_delta(slow);
        c.delta_z    = random_delta(slow);
        c.dwell_time = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3_FFFF);
        send_cmd(c, 1'b0, '0);
      end
    end

    run_rows(tail_at, plan.size());

    in_valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d moves and %0d dwells over %0d register writes",
             n_moves, n_dwells, n_writes);
    $display("%0d results compared, %0d of them flagged saturation; %0d mismatches",
             n_checked, n_sat, errors);
    if (errors == 0) begin
      $display("tb_cnc_move_time_accumulator_core: done, clean");
    end else begin
      $display("tb_cnc_move_time_accumulator_core: done, errors");
    end
    $finish;
  end

endmodule
